FILE: hdl/pnfs_pkg.sv
// ============================================================================
// Packed nibble field store package
// Shared constants, operation codes and types for the nibble field store.
// ============================================================================
package pnfs_pkg;

   // Default sizes, handed to the top-level parameters.
   localparam int STORE_BYTES_DEF = 256;
   localparam int FIELD_COUNT_DEF = 63;

   // The descriptor table has one entry for every field index code.
   localparam int DESC_DEPTH = 64;
   localparam int DESC_BITS  = 17;
   localparam int INDEX_BITS = 6;

   // Fixed byte locations inside the store.
   localparam logic [7:0] NIB_BASE  = 8'd50;
   localparam logic [7:0] FLAG_ADDR = 8'd41;

   // Operation codes on the request channel.
   localparam logic [1:0] FUNC_LOAD = 2'd0;
   localparam logic [1:0] FUNC_GET  = 2'd1;
   localparam logic [1:0] FUNC_SET  = 2'd2;

   // Operations of the shared nibble shift and merge unit.
   typedef logic [1:0] alu_op_type;
   localparam alu_op_type ALU_NIB_SHIFT  = 2'd0;
   localparam alu_op_type ALU_BYTE_SHIFT = 2'd1;
   localparam alu_op_type ALU_NIB_MERGE  = 2'd2;

   // Write strobes from the sequencer to the memories.
   typedef struct packed {
      logic byte_we;
      logic desc_we;
   } mem_ctl_type;

endpackage

FILE: hdl/pnfs_mem.sv
// ============================================================================
// Packed nibble field store memories
// Byte store and descriptor table, each with one write port and one
// registered read port.
// ============================================================================
module pnfs_mem #(
   parameter int STORE_BYTES = pnfs_pkg::STORE_BYTES_DEF,
   parameter int AW          = $clog2(STORE_BYTES)
) (
   input  logic                             clock,
   input  pnfs_pkg::mem_ctl_type            mem_ctl,
   input  logic [AW-1:0]                    byte_waddr,
   input  logic [7:0]                       byte_wdata,
   input  logic [AW-1:0]                    byte_raddr,
   output logic [7:0]                       byte_rdata,
   input  logic [pnfs_pkg::INDEX_BITS-1:0]  desc_waddr,
   input  logic [pnfs_pkg::DESC_BITS-1:0]   desc_wdata,
   input  logic [pnfs_pkg::INDEX_BITS-1:0]  desc_raddr,
   output logic [pnfs_pkg::DESC_BITS-1:0]   desc_rdata
);

   logic [7:0]                     byte_mem [STORE_BYTES];
   logic [pnfs_pkg::DESC_BITS-1:0] desc_mem [pnfs_pkg::DESC_DEPTH];
   logic [7:0]                     byte_rdata_ff;
   logic [pnfs_pkg::DESC_BITS-1:0] desc_rdata_ff;

   // Byte store: read first, read data registered.
   always_ff @(posedge clock) begin
      if (mem_ctl.byte_we) begin
         byte_mem[byte_waddr] <= byte_wdata;
      end
      byte_rdata_ff <= byte_mem[byte_raddr];
   end

   // Descriptor table.
   always_ff @(posedge clock) begin
      if (mem_ctl.desc_we) begin
         desc_mem[desc_waddr] <= desc_wdata;
      end
      desc_rdata_ff <= desc_mem[desc_raddr];
   end

   assign byte_rdata = byte_rdata_ff;
   assign desc_rdata = desc_rdata_ff;

endmodule

FILE: hdl/pnfs_nib_alu.sv
// ============================================================================
// Packed nibble field store shift and merge unit
// Shifts a nibble or a byte into the field accumulator, or merges one
// nibble into a byte read from the store.
// ============================================================================
module pnfs_nib_alu (
   input  pnfs_pkg::alu_op_type  op,
   input  logic [31:0]           acc_i,
   input  logic [7:0]            byte_i,
   input  logic                  sel_high,
   input  logic [3:0]            nib_i,
   output logic [31:0]           acc_o,
   output logic [7:0]            byte_o
);

   logic [3:0] nib_pick;

   // An odd nibble number lives in the high half of its byte.
   assign nib_pick = sel_high ? byte_i[7:4] : byte_i[3:0];

   always_comb begin
      acc_o  = acc_i;
      byte_o = byte_i;
      case (op)
         pnfs_pkg::ALU_NIB_SHIFT: begin
            acc_o = {acc_i[27:0], nib_pick};
         end
         pnfs_pkg::ALU_BYTE_SHIFT: begin
            acc_o = {acc_i[23:0], byte_i};
         end
         pnfs_pkg::ALU_NIB_MERGE: begin
            byte_o = sel_high ? {nib_i, byte_i[3:0]} : {byte_i[7:4], nib_i};
         end
         default: begin
            acc_o  = acc_i;
            byte_o = byte_i;
         end
      endcase
   end

endmodule

FILE: hdl/pnfs_ctrl.sv
// ============================================================================
// Packed nibble field store sequencer
// Steps one request through descriptor lookup, nibble reads or
// read-modify-writes, trail and flag bytes, and holds the response beat.
// ============================================================================
module pnfs_ctrl #(
   parameter int STORE_BYTES = pnfs_pkg::STORE_BYTES_DEF,
   parameter int FIELD_COUNT = pnfs_pkg::FIELD_COUNT_DEF,
   parameter int AW          = $clog2(STORE_BYTES)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_func,
   input  logic [pnfs_pkg::INDEX_BITS-1:0]  req_field_index,
   input  logic [pnfs_pkg::DESC_BITS-1:0]   req_descriptor,
   input  logic [31:0]                      req_write_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [31:0]                      rsp_read_value,
   output logic                             rsp_status,
   output pnfs_pkg::mem_ctl_type            mem_ctl,
   output logic [AW-1:0]                    byte_waddr,
   output logic [7:0]                       byte_wdata,
   output logic [AW-1:0]                    byte_raddr,
   input  logic [7:0]                       byte_rdata,
   output logic [pnfs_pkg::INDEX_BITS-1:0]  desc_waddr,
   output logic [pnfs_pkg::DESC_BITS-1:0]   desc_wdata,
   output logic [pnfs_pkg::INDEX_BITS-1:0]  desc_raddr,
   input  logic [pnfs_pkg::DESC_BITS-1:0]   desc_rdata
);

   localparam logic [3:0] ST_CLEAR     = 4'd0;
   localparam logic [3:0] ST_IDLE      = 4'd1;
   localparam logic [3:0] ST_DESC      = 4'd2;
   localparam logic [3:0] ST_GET_RD    = 4'd3;
   localparam logic [3:0] ST_GET_ACC   = 4'd4;
   localparam logic [3:0] ST_GET_TRAIL = 4'd5;
   localparam logic [3:0] ST_SET_FLAG  = 4'd6;
   localparam logic [3:0] ST_SET_TRAIL = 4'd7;
   localparam logic [3:0] ST_SET_RD    = 4'd8;
   localparam logic [3:0] ST_SET_WR    = 4'd9;
   localparam logic [3:0] ST_DONE      = 4'd10;

   localparam logic [AW-1:0] CLR_LAST = AW'(STORE_BYTES - 1);

   logic [3:0]        state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              is_set_ff, is_set_in;
   logic [31:0]       wv_ff, wv_in;
   logic [5:0]        trail_ff, trail_in;
   logic [8:0]        n_ff, n_in;
   logic [2:0]        rem_ff, rem_in;
   logic [31:0]       acc_ff, acc_in;
   logic [31:0]       val_ff, val_in;
   logic              st_ff, st_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_value_ff, rsp_value_in;
   logic              rsp_status_ff, rsp_status_in;

   logic              accept;
   logic              idx_ok;
   logic [8:0]        prev_n;
   logic [AW-1:0]     cur_addr;
   logic [AW-1:0]     prev_addr;
   logic [AW-1:0]     trail_addr;
   logic [AW-1:0]     flag_addr;
   logic [5:0]        desc_trail;
   pnfs_pkg::alu_op_type alu_op;
   logic [31:0]       alu_acc;
   logic [7:0]        alu_byte;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign idx_ok    = {1'b0, req_field_index} < 7'(FIELD_COUNT);

   // Byte addresses of the current nibble, the one below it, trail and flags.
   assign prev_n     = n_ff - 9'd1;
   assign cur_addr   = AW'(pnfs_pkg::NIB_BASE) + AW'(n_ff[8:1]);
   assign prev_addr  = AW'(pnfs_pkg::NIB_BASE) + AW'(prev_n[8:1]);
   assign trail_addr = AW'(trail_ff);
   assign flag_addr  = AW'(pnfs_pkg::FLAG_ADDR);
   assign desc_trail = desc_rdata[5:0];

   // The descriptor is looked up as the request beat is taken.
   assign desc_raddr = req_field_index;
   assign desc_waddr = (state_ff == ST_CLEAR) ? clr_ff[pnfs_pkg::INDEX_BITS-1:0]
                                              : req_field_index;
   assign desc_wdata = (state_ff == ST_CLEAR) ? '0 : req_descriptor;

   // Shared shift and merge unit.
   always_comb begin
      case (state_ff)
         ST_GET_TRAIL: alu_op = pnfs_pkg::ALU_BYTE_SHIFT;
         ST_SET_WR:    alu_op = pnfs_pkg::ALU_NIB_MERGE;
         default:      alu_op = pnfs_pkg::ALU_NIB_SHIFT;
      endcase
   end

   pnfs_nib_alu u_alu (
      .op       (alu_op),
      .acc_i    (acc_ff),
      .byte_i   (byte_rdata),
      .sel_high (n_ff[0]),
      .nib_i    (val_ff[3:0]),
      .acc_o    (alu_acc),
      .byte_o   (alu_byte)
   );

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      is_set_in     = is_set_ff;
      wv_in         = wv_ff;
      trail_in      = trail_ff;
      n_in          = n_ff;
      rem_in        = rem_ff;
      acc_in        = acc_ff;
      val_in        = val_ff;
      st_in         = st_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      mem_ctl       = '0;
      byte_waddr    = cur_addr;
      byte_wdata    = alu_byte;
      byte_raddr    = cur_addr;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // Zero both memories, one byte address a cycle.
         ST_CLEAR: begin
            mem_ctl.byte_we = 1'b1;
            mem_ctl.desc_we = (clr_ff < AW'(pnfs_pkg::DESC_DEPTH));
            byte_waddr      = clr_ff;
            byte_wdata      = 8'h00;
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         // Decode the request beat.
         ST_IDLE: begin
            if (accept) begin
               is_set_in = (req_func == pnfs_pkg::FUNC_SET);
               wv_in     = req_write_value;
               acc_in    = '0;
               st_in     = 1'b0;
               state_in  = ST_DONE;
               case (req_func)
                  pnfs_pkg::FUNC_LOAD: begin
                     if (idx_ok) begin
                        mem_ctl.desc_we = 1'b1;
                     end else begin
                        acc_in = '1;
                        st_in  = 1'b1;
                     end
                  end
                  pnfs_pkg::FUNC_GET, pnfs_pkg::FUNC_SET: begin
                     if (idx_ok) begin
                        state_in = ST_DESC;
                     end else begin
                        acc_in = '1;
                        st_in  = 1'b1;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         // Unpack the descriptor; a set starts by reading the flag byte.
         ST_DESC: begin
            trail_in = desc_trail;
            rem_in   = desc_rdata[16:14];
            acc_in   = '0;
            if (is_set_ff) begin
               n_in       = {1'b0, desc_rdata[13:6]};
               val_in     = (desc_trail != 6'd0) ? {8'h00, wv_ff[31:8]} : wv_ff;
               byte_raddr = flag_addr;
               state_in   = ST_SET_FLAG;
            end else begin
               n_in     = {1'b0, desc_rdata[13:6]} + {6'd0, desc_rdata[16:14]};
               state_in = ST_GET_RD;
            end
         end
         // Read the top nibble of the field.
         ST_GET_RD: begin
            byte_raddr = cur_addr;
            state_in   = ST_GET_ACC;
         end
         // Shift in one nibble a cycle while the next read is issued.
         ST_GET_ACC: begin
            acc_in = alu_acc;
            if (rem_ff != 3'd0) begin
               byte_raddr = prev_addr;
               n_in       = prev_n;
               rem_in     = rem_ff - 3'd1;
            end else if (trail_ff != 6'd0) begin
               byte_raddr = trail_addr;
               state_in   = ST_GET_TRAIL;
            end else begin
               state_in = ST_DONE;
            end
         end
         // Append the trail byte.
         ST_GET_TRAIL: begin
            acc_in   = alu_acc;
            state_in = ST_DONE;
         end
         // Raise the dirty flags; a trail also sets bit 0.
         ST_SET_FLAG: begin
            mem_ctl.byte_we = 1'b1;
            byte_waddr      = flag_addr;
            byte_wdata      = byte_rdata | 8'h06 | {7'd0, (trail_ff != 6'd0)};
            if (trail_ff != 6'd0 && trail_ff != 6'(pnfs_pkg::FLAG_ADDR)) begin
               state_in = ST_SET_TRAIL;
            end else begin
               state_in = ST_SET_RD;
            end
         end
         // A trail on the flag byte is overwritten by the flags, so skip it.
         ST_SET_TRAIL: begin
            mem_ctl.byte_we = 1'b1;
            byte_waddr      = trail_addr;
            byte_wdata      = wv_ff[7:0];
            state_in        = ST_SET_RD;
         end
         ST_SET_RD: begin
            byte_raddr = cur_addr;
            state_in   = ST_SET_WR;
         end
         // Merge one nibble into its byte, lowest nibble first.
         ST_SET_WR: begin
            mem_ctl.byte_we = 1'b1;
            byte_waddr      = cur_addr;
            byte_wdata      = alu_byte;
            val_in          = {4'h0, val_ff[31:4]};
            if (rem_ff != 3'd0) begin
               rem_in   = rem_ff - 3'd1;
               n_in     = n_ff + 9'd1;
               state_in = ST_SET_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         // Hand the result to the response register once it is free.
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = acc_ff;
               rsp_status_in = st_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      is_set_ff     <= is_set_in;
      wv_ff         <= wv_in;
      trail_ff      <= trail_in;
      n_ff          <= n_in;
      rem_ff        <= rem_in;
      acc_ff        <= acc_in;
      val_ff        <= val_in;
      st_ff         <= st_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

   // The store is never written while waiting for a request.
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_ctl.byte_we)
      else $error("byte store written while idle");

   // Requests are held off during the clearing pass.
   a_clear_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request taken during clearing pass");

   // An invalid field answers with all ones.
   a_invalid_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_read_value == 32'hFFFF_FFFF))
      else $error("invalid field response not all ones");

   // Nibble merges stay inside the nibble area.
   a_merge_in_area: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SET_WR) |-> (byte_waddr >= AW'(pnfs_pkg::NIB_BASE)))
      else $error("nibble write outside nibble area");

   // A response beat is only produced from the done state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid)) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside done state");

endmodule

FILE: hdl/packed_nibble_field_store.sv
// ============================================================================
// Packed nibble field store
// Settings held as packed nibble fields in one byte memory, read and written
// through per-field descriptors.
// ============================================================================
// After reset the block runs a clearing pass over all STORE_BYTES byte addresses
// (256 by default) with req_ready low, zeroing the byte store and the descriptor
// table. Each request then runs alone: a load, an invalid field or an unused
// code goes straight to the response, a get reads the field's nibbles and its
// trail byte, and a set writes the flag byte, the trail byte and the nibbles.
// For a set, a trail byte that falls on the flag byte is not written, since
// the flag write replaces it. The byte store is a single memory with one
// registered read and one write port: a get streams one nibble read a cycle,
// while a set reads and then writes the byte of every nibble. The next request
// is taken while a response beat still waits on rsp_ready.
module packed_nibble_field_store #(
   parameter int STORE_BYTES = pnfs_pkg::STORE_BYTES_DEF,
   parameter int FIELD_COUNT = pnfs_pkg::FIELD_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_func,
   input  logic [pnfs_pkg::INDEX_BITS-1:0]  req_field_index,
   input  logic [pnfs_pkg::DESC_BITS-1:0]   req_descriptor,
   input  logic [31:0]                      req_write_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [31:0]                      rsp_read_value,
   output logic                             rsp_status
);

   localparam int AW = $clog2(STORE_BYTES);

   pnfs_pkg::mem_ctl_type           mem_ctl;
   logic [AW-1:0]                   byte_waddr;
   logic [7:0]                      byte_wdata;
   logic [AW-1:0]                   byte_raddr;
   logic [7:0]                      byte_rdata;
   logic [pnfs_pkg::INDEX_BITS-1:0] desc_waddr;
   logic [pnfs_pkg::DESC_BITS-1:0]  desc_wdata;
   logic [pnfs_pkg::INDEX_BITS-1:0] desc_raddr;
   logic [pnfs_pkg::DESC_BITS-1:0]  desc_rdata;

   // Sequencer with the shared shift and merge unit.
   pnfs_ctrl #(
      .STORE_BYTES (STORE_BYTES),
      .FIELD_COUNT (FIELD_COUNT),
      .AW          (AW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_field_index (req_field_index),
      .req_descriptor  (req_descriptor),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .mem_ctl         (mem_ctl),
      .byte_waddr      (byte_waddr),
      .byte_wdata      (byte_wdata),
      .byte_raddr      (byte_raddr),
      .byte_rdata      (byte_rdata),
      .desc_waddr      (desc_waddr),
      .desc_wdata      (desc_wdata),
      .desc_raddr      (desc_raddr),
      .desc_rdata      (desc_rdata)
   );

   // Byte store and descriptor table.
   pnfs_mem #(
      .STORE_BYTES (STORE_BYTES),
      .AW          (AW)
   ) u_mem (
      .clock      (clock),
      .mem_ctl    (mem_ctl),
      .byte_waddr (byte_waddr),
      .byte_wdata (byte_wdata),
      .byte_raddr (byte_raddr),
      .byte_rdata (byte_rdata),
      .desc_waddr (desc_waddr),
      .desc_wdata (desc_wdata),
      .desc_raddr (desc_raddr),
      .desc_rdata (desc_rdata)
   );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Packed nibble field store testbench
// Loads field descriptors, then sets and gets fields through the request
// channel while a shadow copy of the descriptor table and byte store predicts
// every response. The sender works in bursts and the receiver stalls on its
// own pattern, with long hold-offs and full drains along the way.
// ============================================================================
module tb;

   localparam int STORE_SIZE  = pnfs_pkg::STORE_BYTES_DEF;
   localparam int FIELD_LIMIT = pnfs_pkg::FIELD_COUNT_DEF;
   localparam int unsigned TRAIL_BASE = 0;
   localparam int RANDOM_BEATS = 1550;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int TAIL_CYCLES  = 40;
   localparam int HOLD_CYCLES  = 300;

   // Code 3 on the function field is unused and answered with zero.
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   typedef struct {
      logic [1:0]  func;
      logic [5:0]  index;
      logic [16:0] desc;
      logic [31:0] wval;
      bit          hold_first;
   } req_beat_type;

   typedef struct {
      logic [31:0] value;
      logic        status;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0]  req_func = pnfs_pkg::FUNC_LOAD;
   logic [5:0]  req_field_index = '0;
   logic [16:0] req_descriptor = '0;
   logic [31:0] req_write_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_read_value;
   logic rsp_status;

   // Beats waiting to be offered, and responses predicted but not yet seen.
   req_beat_type req_backlog[$];
   answer_type   answers_due[$];

   // Shadow copy of the block's state.
   logic [16:0] shadow_desc[64];
   logic [7:0]  shadow_mem[STORE_SIZE];

   int sent_count = 0;
   int done_count = 0;
   int total_beats = 0;
   int mismatch_count = 0;
   int n_load = 0, n_get = 0, n_set = 0, n_bad = 0, n_spare = 0;
   int cycle_count = 0;

   packed_nibble_field_store #(
      .STORE_BYTES(STORE_SIZE),
      .FIELD_COUNT(FIELD_LIMIT)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_field_index(req_field_index),
      .req_descriptor(req_descriptor),
      .req_write_value(req_write_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_value(rsp_read_value),
      .rsp_status(rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Shadow model of the store
   // ------------------------------------------------------------------------
   function automatic logic [7:0] mem_rd(int unsigned addr);
      return shadow_mem[addr % STORE_SIZE];
   endfunction

   function automatic void mem_wr(int unsigned addr, logic [7:0] data);
      shadow_mem[addr % STORE_SIZE] = data;
   endfunction

   // Gathers a field from its top nibble down, then appends the trail byte.
   function automatic logic [31:0] field_read(logic [16:0] desc);
      int unsigned width, cursor, pos;
      logic [31:0] value;
      logic [7:0]  b;
      width  = 32'(desc[16:14]) + 1;
      cursor = 32'(desc[13:6]) + width;
      pos    = cursor >> 1;
      value  = '0;
      if (cursor[0]) begin
         b = mem_rd(pnfs_pkg::NIB_BASE + pos);
         value = {28'd0, b[3:0]};
         width = width - 1;
      end
      while (width != 0) begin
         pos = pos - 1;
         b = mem_rd(pnfs_pkg::NIB_BASE + pos);
         if (width == 1) begin
            value = (value << 4) | {28'd0, b[7:4]};
            width = 0;
         end else begin
            value = (value << 8) | {24'd0, b};
            width = width - 2;
         end
      end
      if (desc[5:0] != 6'd0) begin
         b = mem_rd(TRAIL_BASE + 32'(desc[5:0]));
         value = (value << 8) | {24'd0, b};
      end
      return value;
   endfunction

   // Writes the trail byte and flags first, then the nibbles from the bottom up.
   function automatic void field_write(logic [16:0] desc, logic [31:0] wval);
      int unsigned width, start, pos;
      logic [31:0] value;
      logic [7:0]  b;
      logic [7:0]  flags;
      width = 32'(desc[16:14]) + 1;
      start = 32'(desc[13:6]);
      pos   = start >> 1;
      value = wval;
      if (desc[5:0] != 6'd0) begin
         flags = mem_rd(pnfs_pkg::FLAG_ADDR);
         mem_wr(TRAIL_BASE + 32'(desc[5:0]), value[7:0]);
         mem_wr(pnfs_pkg::FLAG_ADDR, flags | 8'h01);
         value = value >> 8;
      end
      mem_wr(pnfs_pkg::FLAG_ADDR, mem_rd(pnfs_pkg::FLAG_ADDR) | 8'h06);
      if (start[0]) begin
         b = mem_rd(pnfs_pkg::NIB_BASE + pos);
         mem_wr(pnfs_pkg::NIB_BASE + pos, {value[3:0], b[3:0]});
         pos = pos + 1;
         width = width - 1;
         value = value >> 4;
      end
      while (width != 0) begin
         if (width == 1) begin
            b = mem_rd(pnfs_pkg::NIB_BASE + pos);
            mem_wr(pnfs_pkg::NIB_BASE + pos, {b[7:4], value[3:0]});
            width = 0;
         end else begin
            width = width - 2;
            mem_wr(pnfs_pkg::NIB_BASE + pos, value[7:0]);
            pos = pos + 1;
            value = value >> 8;
         end
      end
   endfunction

   // Applies one request beat to the shadow state and returns its response.
   function automatic answer_type predict_answer(req_beat_type rq);
      answer_type ans;
      ans.value  = '0;
      ans.status = 1'b0;
      if (rq.func != FUNC_SPARE && rq.index >= FIELD_LIMIT) begin
         ans.value  = '1;
         ans.status = 1'b1;
         n_bad++;
      end else begin
         case (rq.func)
            pnfs_pkg::FUNC_LOAD: begin
               shadow_desc[rq.index] = rq.desc;
               n_load++;
            end
            pnfs_pkg::FUNC_GET: begin
               ans.value = field_read(shadow_desc[rq.index]);
               n_get++;
            end
            pnfs_pkg::FUNC_SET: begin
               field_write(shadow_desc[rq.index], rq.wval);
               n_set++;
            end
            default: n_spare++;
         endcase
      end
      return ans;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [16:0] make_desc(int nibbles, int start, int trail);
      logic [2:0] wm;
      logic [7:0] st;
      logic [5:0] tr;
      wm = 3'(nibbles - 1);
      st = 8'(start);
      tr = 6'(trail);
      return {wm, st, tr};
   endfunction

   function automatic void add_beat(logic [1:0] func, logic [5:0] index,
                                    logic [16:0] desc, logic [31:0] wval,
                                    bit hold_first);
      req_beat_type rq;
      rq.func = func;
      rq.index = index;
      rq.desc = desc;
      rq.wval = wval;
      rq.hold_first = hold_first;
      req_backlog.push_back(rq);
   endfunction

   function automatic logic [16:0] random_desc();
      int tr;
      int pick;
      if ($urandom_range(0, 4) == 0)
         return 17'($urandom());
      pick = int'($urandom_range(0, 9));
      if (pick < 4)
         tr = 0;
      else if (pick == 4)
         tr = int'(pnfs_pkg::FLAG_ADDR);
      else if (pick == 5)
         tr = int'($urandom_range(50, 63));
      else
         tr = int'($urandom_range(1, 63));
      return make_desc(int'($urandom_range(1, 8)), int'($urandom_range(0, 255)), tr);
   endfunction

   function automatic logic [31:0] random_word();
      int pick;
      pick = int'($urandom_range(0, 19));
      if (pick == 0)
         return '0;
      if (pick == 1)
         return '1;
      return $urandom();
   endfunction

   // Most traffic goes to a small working set of fields so gets see earlier sets.
   task automatic build_random_traffic();
      logic [5:0] hot[8];
      logic [5:0] idx;
      logic [1:0] func;
      bit hold;
      int r;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 200 == 0) begin
            foreach (hot[k])
               hot[k] = ($urandom_range(0, 30) == 0) ? 6'd63
                                                      : 6'($urandom_range(0, 62));
         end
         hold = (n == 0) || (n % 300 == 150) || ($urandom_range(0, 149) == 0);
         idx = ($urandom_range(0, 99) < 80) ? hot[$urandom_range(0, 7)]
                                            : 6'($urandom_range(0, 62));
         r = int'($urandom_range(0, 99));
         if (r < 15)
            func = pnfs_pkg::FUNC_LOAD;
         else if (r < 50)
            func = pnfs_pkg::FUNC_GET;
         else if (r < 88)
            func = pnfs_pkg::FUNC_SET;
         else if (r < 94) begin
            func = FUNC_SPARE;
            idx = 6'($urandom_range(0, 63));
         end else begin
            func = 2'($urandom_range(0, 2));
            idx = 6'd63;
         end
         add_beat(func, idx, random_desc(), random_word(), hold);
      end
   endtask

   task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("MISMATCH %s at response %0d: expected %h, got %h",
                  what, done_count, exp_v, got_v);
   endtask

   // ------------------------------------------------------------------------
   // Driver: offers backlog beats in bursts with random gaps.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_proc
      int gap_left;
      int burst_left;
      bit fire;
      bit offer;
      req_beat_type rq;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         burst_left = 0;
      end else begin
         fire = req_valid && req_ready;
         if (fire)
            sent_count <= sent_count + 1;
         if (!(req_valid && !fire)) begin
            offer = 1'b0;
            if (burst_left == 0 && gap_left == 0) begin
               if ($urandom_range(0, 99) < 15) begin
                  burst_left = int'($urandom_range(60, 150));
                  gap_left = 0;
               end else begin
                  burst_left = int'($urandom_range(1, 20));
                  gap_left = int'($urandom_range(0, 8));
               end
            end
            if (gap_left > 0)
               gap_left--;
            else if (req_backlog.size() > 0) begin
               // A marked beat waits until every earlier response has come back.
               if (!(req_backlog[0].hold_first &&
                     (sent_count + int'(fire)) != done_count)) begin
                  rq = req_backlog.pop_front();
                  req_func <= rq.func;
                  req_field_index <= rq.index;
                  req_descriptor <= rq.desc;
                  req_write_value <= rq.wval;
                  offer = 1'b1;
                  if (burst_left > 0)
                     burst_left--;
               end
            end
            req_valid <= offer;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: changing stall patterns plus occasional long hold-offs.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : recv_proc
      int mode;
      int mode_left;
      int hold_left;
      int hold_at;
      int pat;
      logic ready_next;
      if (reset) begin
         rsp_ready <= 1'b0;
         mode = 0;
         mode_left = 0;
         hold_left = 0;
         hold_at = 400;
         pat = 0;
      end else begin
         if (hold_left == 0 && sent_count >= hold_at) begin
            hold_left = HOLD_CYCLES;
            hold_at = hold_at + 700;
         end
         if (mode_left == 0) begin
            mode = int'($urandom_range(0, 3));
            mode_left = int'($urandom_range(30, 250));
         end
         mode_left--;
         pat++;
         case (mode)
            0: ready_next = 1'b1;
            1: ready_next = 1'($urandom_range(0, 1));
            2: ready_next = ($urandom_range(0, 4) == 0);
            default: ready_next = (pat % 7) >= 3;
         endcase
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end
         rsp_ready <= ready_next;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: predicts on each request beat, checks each response beat.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_proc
      req_beat_type rq;
      answer_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            rq.func = req_func;
            rq.index = req_field_index;
            rq.desc = req_descriptor;
            rq.wval = req_write_value;
            rq.hold_first = 1'b0;
            answers_due.push_back(predict_answer(rq));
         end
         if (rsp_valid && rsp_ready) begin
            done_count <= done_count + 1;
            if (answers_due.size() == 0)
               report_mismatch("unexpected response", 32'd0, rsp_read_value);
            else begin
               want = answers_due.pop_front();
               if (rsp_read_value !== want.value)
                  report_mismatch("read_value", want.value, rsp_read_value);
               if (rsp_status !== want.status)
                  report_mismatch("status", {31'd0, want.status}, {31'd0, rsp_status});
            end
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d of %0d beats sent, %0d responses",
                  cycle_count, sent_count, total_beats, done_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Directed beats, random traffic, reset and the end of the run.
   // ------------------------------------------------------------------------
   initial begin
      foreach (shadow_desc[i])
         shadow_desc[i] = '0;
      foreach (shadow_mem[i])
         shadow_mem[i] = '0;

      // Untouched field reads back zero after reset.
      add_beat(pnfs_pkg::FUNC_GET, 6'd0, '0, '0, 1'b0);
      // Widest field from nibble 0 with the highest trail index.
      add_beat(pnfs_pkg::FUNC_LOAD, 6'd0, make_desc(8, 0, 63), '0, 1'b0);
      add_beat(pnfs_pkg::FUNC_SET, 6'd0, '0, 32'hFFFF_FFFF, 1'b0);
      add_beat(pnfs_pkg::FUNC_GET, 6'd0, '0, '0, 1'b0);
      // Narrowest field on the last nibble, no trail.
      add_beat(pnfs_pkg::FUNC_LOAD, 6'd62, make_desc(1, 255, 0), '0, 1'b0);
      add_beat(pnfs_pkg::FUNC_SET, 6'd62, '0, 32'hFFFF_FFFF, 1'b0);
      add_beat(pnfs_pkg::FUNC_GET, 6'd62, '0, '0, 1'b0);
      // Trail byte lands on the flag byte.
      add_beat(pnfs_pkg::FUNC_LOAD, 6'd1,
               make_desc(8, 255, int'(pnfs_pkg::FLAG_ADDR)), '0, 1'b0);
      add_beat(pnfs_pkg::FUNC_SET, 6'd1, '0, 32'hA5C3_9E17, 1'b0);
      add_beat(pnfs_pkg::FUNC_GET, 6'd1, '0, '0, 1'b0);
      // Trail byte lands inside the nibble area that the field itself covers.
      add_beat(pnfs_pkg::FUNC_LOAD, 6'd2, make_desc(5, 3, 52), '0, 1'b0);
      add_beat(pnfs_pkg::FUNC_SET, 6'd2, '0, 32'h1234_5678, 1'b0);
      add_beat(pnfs_pkg::FUNC_GET, 6'd2, '0, '0, 1'b0);
      // Invalid field index for each operation.
      add_beat(pnfs_pkg::FUNC_LOAD, 6'd63, 17'h1FFFF, '0, 1'b0);
      add_beat(pnfs_pkg::FUNC_GET, 6'd63, '0, '0, 1'b0);
      add_beat(pnfs_pkg::FUNC_SET, 6'd63, '0, 32'hFFFF_FFFF, 1'b0);
      // Unused function code, with an invalid and a valid index.
      add_beat(FUNC_SPARE, 6'd63, 17'h1FFFF, 32'hFFFF_FFFF, 1'b0);
      add_beat(FUNC_SPARE, 6'd5, '0, '0, 1'b0);
      // Clearing a field and reading it back.
      add_beat(pnfs_pkg::FUNC_SET, 6'd0, '0, 32'h0000_0000, 1'b0);
      add_beat(pnfs_pkg::FUNC_GET, 6'd0, '0, '0, 1'b0);
      // All-ones descriptor: widest field at the top nibble, highest trail.
      add_beat(pnfs_pkg::FUNC_LOAD, 6'd3, 17'h1FFFF, '0, 1'b0);
      add_beat(pnfs_pkg::FUNC_SET, 6'd3, '0, 32'hFFFF_FFFF, 1'b0);
      add_beat(pnfs_pkg::FUNC_GET, 6'd3, '0, '0, 1'b0);
      add_beat(pnfs_pkg::FUNC_GET, 6'd1, '0, '0, 1'b0);

      build_random_traffic();
      total_beats = req_backlog.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (sent_count != total_beats)
         @(posedge clock);
      while (done_count != sent_count)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (answers_due.size() != 0) begin
         $display("%0d expected responses never arrived", answers_due.size());
         mismatch_count = mismatch_count + answers_due.size();
      end

      $display("Checked %0d responses: %0d loads, %0d gets, %0d sets,",
               done_count, n_load, n_get, n_set);
      $display("  %0d invalid-index beats, %0d unused-code beats, %0d mismatches.",
               n_bad, n_spare, mismatch_count);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
